// File: hdl/pch_pkg.sv
// Package with the constants, codes and types of the pair co-occurrence hash counter.
package pch_pkg;

    localparam int unsigned SLOT_BITS   = 12;
    localparam int unsigned TABLE_SLOTS = 1 << SLOT_BITS;
    localparam int unsigned OCC_BITS    = SLOT_BITS + 1;
    localparam int unsigned KEY_BITS    = 64;
    localparam int unsigned CNT_BITS    = 32;
    localparam int unsigned STAT_BITS   = 3;

    localparam logic [KEY_BITS-1:0] HASH_MULT = 64'd1099511628211;

    // New keys are refused once occupied * 10 >= slots * 7.
    localparam logic [OCC_BITS+3:0] LOAD_LIMIT = (OCC_BITS+4)'((TABLE_SLOTS * 7 + 9) / 10);

    localparam logic [STAT_BITS-1:0] ST_INCREMENTED = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_INSERTED    = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL        = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_INVALID     = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_READ        = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified job passed from the front end to the table engine.
    typedef struct packed {
        logic                 is_read;
        logic                 is_invalid;
        logic [KEY_BITS-1:0]  key;
        logic [SLOT_BITS-1:0] slot;
    } t_job;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [SLOT_BITS-1:0] slot;
        logic [KEY_BITS-1:0]  stored_key;
        logic [CNT_BITS-1:0]  pair_count;
    } t_result;

endpackage

// File: hdl/pch_front.sv
// Front end: accepts input words, hashes the key and queues classified jobs.
module pch_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_kind,
    input  logic [pch_pkg::KEY_BITS-1:0]      i_pair_key,
    input  logic [pch_pkg::SLOT_BITS-1:0]     i_slot_index,
    output logic                              o_job_valid,
    output pch_pkg::t_job                     o_job,
    input  logic                              i_job_take
);

    // Stage 1 registers the item; the hash multiply works on that register as the job enters the queue.
    logic                          r_s1_valid;
    logic                          r_s1_kind;
    logic [pch_pkg::KEY_BITS-1:0]  r_s1_key;
    logic [pch_pkg::SLOT_BITS-1:0] r_s1_idx;

    pch_pkg::t_job r_q [pch_pkg::QUEUE_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [pch_pkg::SLOT_BITS-1:0] w_prod;
    pch_pkg::t_job w_job;
    logic          w_s1_move;
    logic          w_push_ok;

    // Stage 1 may hand off only when the queue has a free entry.
    assign w_s1_move = r_s1_valid && (r_cnt != 2'd2);
    assign o_full    = r_s1_valid && !w_s1_move;
    assign w_push_ok = i_push && !o_full;

    // Only the low product bits pick the home slot, and they depend only on
    // the low bits of both factors.
    assign w_prod = r_s1_key[pch_pkg::SLOT_BITS-1:0] * pch_pkg::HASH_MULT[pch_pkg::SLOT_BITS-1:0];

    always_comb begin
        w_job.is_read    = r_s1_kind;
        w_job.is_invalid = !r_s1_kind && (r_s1_key == '0);
        w_job.key        = r_s1_key;
        w_job.slot       = r_s1_kind ? r_s1_idx : w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_wp <= ~r_wp;
            end
            if (i_job_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_s1_move} - {1'b0, i_job_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_s1_kind <= i_kind;
            r_s1_key  <= i_pair_key;
            r_s1_idx  <= i_slot_index;
        end
        if (w_s1_move) begin
            r_q[r_wp] <= w_job;
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

endmodule

// File: hdl/pch_engine.sv
// Table engine: probes the key and count memories and produces one result per job.
module pch_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  pch_pkg::t_job         i_job,
    output logic                  o_job_take,
    output logic                  o_res_valid,
    output pch_pkg::t_result      o_res,
    input  logic                  i_res_take
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [pch_pkg::KEY_BITS-1:0] r_key_mem [pch_pkg::TABLE_SLOTS];
    logic [pch_pkg::CNT_BITS-1:0] r_cnt_mem [pch_pkg::TABLE_SLOTS];

    logic [2:0]                    r_state, n_state;
    logic [pch_pkg::SLOT_BITS:0]   r_clr;
    logic [pch_pkg::SLOT_BITS-1:0] r_addr;
    logic [pch_pkg::SLOT_BITS:0]   r_probes;
    pch_pkg::t_job                 r_job;
    logic [pch_pkg::KEY_BITS-1:0]  r_rd_key;
    logic [pch_pkg::CNT_BITS-1:0]  r_rd_cnt;
    logic [pch_pkg::OCC_BITS-1:0]  r_occ;
    pch_pkg::t_result              r_res;
    logic                          r_res_valid;

    logic w_kwe, w_cwe;
    logic [pch_pkg::SLOT_BITS-1:0] w_waddr;
    logic [pch_pkg::KEY_BITS-1:0]  w_wkey;
    logic [pch_pkg::CNT_BITS-1:0]  w_wcnt;
    logic [pch_pkg::CNT_BITS-1:0]  w_inc;
    logic                          w_at_limit;

    assign w_inc      = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + 1'b1;
    assign w_at_limit = {4'd0, r_occ} >= pch_pkg::LOAD_LIMIT;
    assign o_job_take = (r_state == S_IDLE) && i_job_valid && !r_res_valid;

    always_comb begin
        w_kwe   = 1'b0;
        w_cwe   = 1'b0;
        w_waddr = r_addr;
        w_wkey  = r_job.key;
        w_wcnt  = w_inc;
        if (r_state == S_CLEAR) begin
            w_kwe   = 1'b1;
            w_waddr = r_clr[pch_pkg::SLOT_BITS-1:0];
            w_wkey  = '0;
        end else if (r_state == S_CHECK && !r_job.is_read) begin
            if (r_rd_key == r_job.key) begin
                w_cwe = 1'b1;
            end else if (r_rd_key == '0 && !w_at_limit) begin
                w_kwe  = 1'b1;
                w_cwe  = 1'b1;
                w_wcnt = 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_key_mem[w_waddr] <= w_wkey;
        end
        if (w_cwe) begin
            r_cnt_mem[w_waddr] <= w_wcnt;
        end
        if (r_state == S_READ) begin
            r_rd_key <= r_key_mem[r_addr];
            r_rd_cnt <= r_cnt_mem[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == (pch_pkg::SLOT_BITS+1)'(pch_pkg::TABLE_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (o_job_take) n_state = i_job.is_invalid ? S_OUT : S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_job.is_read || r_rd_key == r_job.key || r_rd_key == '0
                        || r_probes == (pch_pkg::SLOT_BITS+1)'(pch_pkg::TABLE_SLOTS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_kwe && r_state == S_CHECK) begin
                r_occ <= r_occ + 1'b1;
            end
            if (r_state == S_OUT) begin
                r_res_valid <= 1'b1;
            end else if (i_res_take) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job    <= i_job;
            r_addr   <= i_job.slot;
            r_probes <= '0;
            r_res    <= '{status: pch_pkg::ST_INVALID, slot: '0, stored_key: '0, pair_count: '0};
        end
        if (r_state == S_CHECK) begin
            r_res.slot <= r_addr;
            if (r_job.is_read) begin
                r_res.status     <= pch_pkg::ST_READ;
                r_res.stored_key <= r_rd_key;
                r_res.pair_count <= (r_rd_key == '0) ? '0 : r_rd_cnt;
            end else if (r_rd_key == r_job.key) begin
                r_res.status     <= pch_pkg::ST_INCREMENTED;
                r_res.stored_key <= r_job.key;
                r_res.pair_count <= w_inc;
            end else if (r_rd_key == '0 && !w_at_limit) begin
                r_res.status     <= pch_pkg::ST_INSERTED;
                r_res.stored_key <= r_job.key;
                r_res.pair_count <= 1;
            end else begin
                r_res.status     <= pch_pkg::ST_FULL;
                r_res.stored_key <= '0;
                r_res.pair_count <= '0;
            end
            r_addr   <= r_addr + 1'b1;
            r_probes <= r_probes + 1'b1;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: hdl/pair_cooccurrence_hash_counter.sv
// Top level of the pair co-occurrence hash counter.
//
// The block counts 64-bit packed term-pair keys in a 4096-slot hash table with
// linear probing. Both sides look like a queue. A word is written with i_push
// while o_full is low; kind 0 counts i_pair_key, kind 1 reads slot i_slot_index.
// Each word yields exactly one result word, shown on the o_ ports while o_empty
// is low and removed by i_pop.
//
// A front end registers the word, forms the home slot from the key times the
// hash constant and moves the job into a two-entry queue once it has a free
// entry. The engine takes a job when idle, runs a read state (key and count
// memory read) and a check state (compare and write) for each probed slot,
// and an out state to post the result. The engine takes its next job only
// from the cycle after its result was popped, so it works on one word at a
// time. The front holds up to three words while the engine is busy.
//
// After reset the engine sweeps the key memory to zero, one slot a cycle,
// over all 4096 slots; words may be queued but are not executed until it
// ends. When the receiver does not pop, the result register holds and the
// engine stops; the front queue then fills and o_full rises.
module pair_cooccurrence_hash_counter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_kind,
    input  logic [pch_pkg::KEY_BITS-1:0]      i_pair_key,
    input  logic [pch_pkg::SLOT_BITS-1:0]     i_slot_index,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [pch_pkg::STAT_BITS-1:0]     o_status,
    output logic [pch_pkg::SLOT_BITS-1:0]     o_slot,
    output logic [pch_pkg::KEY_BITS-1:0]      o_stored_key,
    output logic [pch_pkg::CNT_BITS-1:0]      o_pair_count
);

    logic             w_job_valid;
    pch_pkg::t_job    w_job;
    logic             w_job_take;
    logic             w_res_valid;
    pch_pkg::t_result w_res;
    logic             w_res_take;

    pch_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_kind       (i_kind),
        .i_pair_key   (i_pair_key),
        .i_slot_index (i_slot_index),
        .o_job_valid  (w_job_valid),
        .o_job        (w_job),
        .i_job_take   (w_job_take)
    );

    pch_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_take  (w_job_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    assign o_empty      = !w_res_valid;
    assign w_res_take   = i_pop && w_res_valid;
    assign o_status     = w_res.status;
    assign o_slot       = w_res.slot;
    assign o_stored_key = w_res.stored_key;
    assign o_pair_count = w_res.pair_count;

    // A job is only taken by the engine when a job is queued.
    a_take_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_take |-> w_job_valid)
        else $error("engine took a job from an empty queue");

    // An invalid result never carries a key or a count.
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status == pch_pkg::ST_INVALID)
            |-> (o_stored_key == '0 && o_pair_count == '0))
        else $error("invalid-key result carries data");

    // Insert results always report a count of one.
    a_insert_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status == pch_pkg::ST_INSERTED) |-> (o_pair_count == 32'd1))
        else $error("insert result with count other than one");

endmodule

// File: test/tb_pair_cooccurrence_hash_counter.sv
// Testbench for the pair co-occurrence hash counter: queue driver, monitor and table predictor.
module tb_pair_cooccurrence_hash_counter;

    // Two kinds of input word.
    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Cycles without any handshake before the run is declared hung. The limit is set well
    // above the time of the post-reset sweep plus a long probe chain.
    localparam int unsigned STALL_LIMIT = 40000;

    typedef struct {
        logic                          kind;
        logic [pch_pkg::KEY_BITS-1:0]  key;
        logic [pch_pkg::SLOT_BITS-1:0] index;
    } t_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_push = 1'b0;
    logic                          o_full;
    logic                          i_kind = 1'b0;
    logic [pch_pkg::KEY_BITS-1:0]  i_pair_key = '0;
    logic [pch_pkg::SLOT_BITS-1:0] i_slot_index = '0;
    logic                          o_empty;
    logic                          i_pop = 1'b0;
    logic [pch_pkg::STAT_BITS-1:0] o_status;
    logic [pch_pkg::SLOT_BITS-1:0] o_slot;
    logic [pch_pkg::KEY_BITS-1:0]  o_stored_key;
    logic [pch_pkg::CNT_BITS-1:0]  o_pair_count;

    pair_cooccurrence_hash_counter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_kind       (i_kind),
        .i_pair_key   (i_pair_key),
        .i_slot_index (i_slot_index),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_stored_key (o_stored_key),
        .o_pair_count (o_pair_count)
    );

    always #10 i_clk = ~i_clk;

    // Words waiting to be pushed and results the predictor has produced.
    t_word            words_to_send[$];
    pch_pkg::t_result pending_results[$];

    // Predictor's own copy of the table.
    logic [pch_pkg::KEY_BITS-1:0] model_keys[pch_pkg::TABLE_SLOTS];
    logic [pch_pkg::CNT_BITS-1:0] model_counts[pch_pkg::TABLE_SLOTS];
    int unsigned                  model_occupied = 0;

    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned status_hits[5] = '{default: 0};
    int unsigned quiet_cycles = 0;

    // Applies one word to the predictor's table and returns the expected result.
    function automatic pch_pkg::t_result table_lookup(t_word w);
        pch_pkg::t_result              r;
        logic [pch_pkg::KEY_BITS-1:0]  product;
        logic [pch_pkg::SLOT_BITS-1:0] s;
        int unsigned                   probes;
        r = '0;
        if (w.kind == KIND_READ) begin
            s = w.index;
            r.status = pch_pkg::ST_READ;
            r.slot = s;
            r.stored_key = model_keys[s];
            r.pair_count = (model_keys[s] != '0) ? model_counts[s] : '0;
            return r;
        end
        if (w.key == '0) begin
            r.status = pch_pkg::ST_INVALID;
            return r;
        end
        product = w.key * pch_pkg::HASH_MULT;
        s = product[pch_pkg::SLOT_BITS-1:0];
        probes = 0;
        while (model_keys[s] != '0 && probes < pch_pkg::TABLE_SLOTS) begin
            if (model_keys[s] == w.key) begin
                if (model_counts[s] != '1) begin
                    model_counts[s] = model_counts[s] + 1'b1;
                end
                r.status = pch_pkg::ST_INCREMENTED;
                r.slot = s;
                r.stored_key = w.key;
                r.pair_count = model_counts[s];
                return r;
            end
            s = s + 1'b1;
            probes++;
        end
        r.slot = s;
        if (model_keys[s] != '0 || model_occupied * 10 >= pch_pkg::TABLE_SLOTS * 7) begin
            r.status = pch_pkg::ST_FULL;
            return r;
        end
        model_keys[s] = w.key;
        model_counts[s] = 1;
        model_occupied++;
        r.status = pch_pkg::ST_INSERTED;
        r.stored_key = w.key;
        r.pair_count = 1;
        return r;
    endfunction

    // Prints one line per mismatch and keeps the tally.
    task automatic report_mismatch(string what, logic [pch_pkg::KEY_BITS-1:0] got,
                                   logic [pch_pkg::KEY_BITS-1:0] want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    endtask

    // The idle rate is about 11 percent except in a quiet stretch of the run.
    function automatic logic take_a_break(int unsigned progress);
        if (progress >= 1000 && progress < 1600) begin
            return 1'b0;
        end
        return $urandom_range(99) < 11;
    endfunction

    // Driver: a word is taken when push is high and full is low; only then, or when
    // push is low, may the next word be placed on the ports.
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                w.kind = i_kind;
                w.key = i_pair_key;
                w.index = i_slot_index;
                pending_results.push_back(table_lookup(w));
                words_sent++;
            end
            if (!i_push || !o_full) begin
                if (words_to_send.size() > 0 && !take_a_break(words_sent)) begin
                    w = words_to_send.pop_front();
                    i_push <= 1'b1;
                    i_kind <= w.kind;
                    i_pair_key <= w.key;
                    i_slot_index <= w.index;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // Monitor: every popped word is compared with the oldest expected result.
    always @(posedge i_clk) begin
        pch_pkg::t_result want;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", o_stored_key, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status <= pch_pkg::ST_READ) begin
                        status_hits[o_status]++;
                    end
                    if (o_status !== want.status) begin
                        report_mismatch("status", pch_pkg::KEY_BITS'(o_status),
                                        pch_pkg::KEY_BITS'(want.status));
                    end
                    if (o_slot !== want.slot) begin
                        report_mismatch("slot", pch_pkg::KEY_BITS'(o_slot),
                                        pch_pkg::KEY_BITS'(want.slot));
                    end
                    if (o_stored_key !== want.stored_key) begin
                        report_mismatch("stored_key", o_stored_key, want.stored_key);
                    end
                    if (o_pair_count !== want.pair_count) begin
                        report_mismatch("pair_count", pch_pkg::KEY_BITS'(o_pair_count),
                                        pch_pkg::KEY_BITS'(want.pair_count));
                    end
                end
            end
            i_pop <= !take_a_break(results_seen);
        end
    end

    // Watchdog: counts cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake", quiet_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_count(logic [pch_pkg::KEY_BITS-1:0] key);
        t_word w;
        w.kind = KIND_COUNT;
        w.key = key;
        w.index = pch_pkg::SLOT_BITS'($urandom);
        words_to_send.push_back(w);
    endtask

    task automatic add_read(logic [pch_pkg::SLOT_BITS-1:0] index);
        t_word w;
        w.kind = KIND_READ;
        w.key = {$urandom, $urandom};
        w.index = index;
        words_to_send.push_back(w);
    endtask

    initial begin
        logic [pch_pkg::KEY_BITS-1:0] product;
        logic [pch_pkg::KEY_BITS-1:0] last_slot_key;
        logic [pch_pkg::KEY_BITS-1:0] known_keys[$];
        logic [pch_pkg::KEY_BITS-1:0] key;
        int unsigned                  pick;

        for (int i = 0; i < pch_pkg::TABLE_SLOTS; i++) begin
            model_keys[i] = '0;
            model_counts[i] = '0;
        end

        // A key whose home is the last slot, so that its collision chain wraps to slot 0.
        last_slot_key = 1;
        for (int k = 1; k < pch_pkg::TABLE_SLOTS; k++) begin
            product = pch_pkg::KEY_BITS'(k) * pch_pkg::HASH_MULT;
            if (product[pch_pkg::SLOT_BITS-1:0] == '1) begin
                last_slot_key = pch_pkg::KEY_BITS'(k);
            end
        end

        // Directed words: zero key, extreme keys, a collision chain that wraps around
        // the end of the table, repeat counts and reads of empty and filled slots.
        add_count('0);
        add_count('1);
        add_count('1);
        add_count(64'd1);
        add_count(last_slot_key);
        add_count(last_slot_key + 64'd4096);
        add_count(last_slot_key + 64'd8192);
        add_count(last_slot_key + 64'd8192);
        add_count(last_slot_key + 64'd4096);
        add_read('0);
        add_read('1);
        add_read(12'd1);
        add_read(12'd2);
        add_read(12'hAAA);
        add_read(12'h555);
        add_count(64'h8000_0000_0000_0000);
        add_count(64'h0000_0001_0000_0002);
        add_count('0);
        known_keys = '{64'd1, '1, last_slot_key, last_slot_key + 64'd4096,
                       last_slot_key + 64'd8192};

        // Fill phase: mostly fresh keys, filling about a quarter of the table, with
        // colliding keys, repeats, reads and zero keys mixed in.
        for (int n = 0; n < 1400; n++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                key = {$urandom, $urandom};
                if (key == '0) begin
                    key = 64'd7;
                end
                known_keys.push_back(key);
                add_count(key);
            end else if (pick < 80) begin
                key = known_keys[$urandom_range(known_keys.size() - 1)] + 64'd4096;
                known_keys.push_back(key);
                add_count(key);
            end else if (pick < 92) begin
                add_count(known_keys[$urandom_range(known_keys.size() - 1)]);
            end else if (pick < 98) begin
                add_read(pch_pkg::SLOT_BITS'($urandom));
            end else begin
                add_count('0);
            end
        end

        // Steady phase: repeats, further fresh keys, reads of random slots and zero keys.
        for (int n = 0; n < 580; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                add_count(known_keys[$urandom_range(known_keys.size() - 1)]);
            end else if (pick < 60) begin
                add_count({$urandom, $urandom} | 64'd1);
            end else if (pick < 97) begin
                add_read(pch_pkg::SLOT_BITS'($urandom));
            end else begin
                add_count('0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() > 0 || i_push || pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        // Then wait on, to catch any stray result word.
        repeat (50) @(posedge i_clk);

        $display("Sent %0d words and checked %0d results with %0d mismatches.",
                 words_sent, results_seen, mismatches);
        $display("Increments %0d, inserts %0d, refusals %0d, zero keys %0d, reads %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
